// ===== hdl/sdrs_pkg.sv =====
package sdrs_pkg;

    // Fixed field widths of the item and register formats.
    localparam int DX_W        = 24;
    localparam int REP_W       = 8;
    localparam int BL_W        = 15;
    localparam int DM_W        = 7;
    localparam int RPT_W       = 4;
    localparam int CNT_W       = 4;
    localparam int MAX_REPORTS = 8;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    // Command queue between the front and the back.
    localparam int Q_DEPTH = 2;
    localparam int QA_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // Register indexes, taken from paddr word bits.
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_BACKLOG_LIMIT    = 2'd0;
    localparam t_reg_idx REG_DELTA_MAX        = 2'd1;
    localparam t_reg_idx REG_DELTA_MIN        = 2'd2;
    localparam t_reg_idx REG_REPORTS_PER_TICK = 2'd3;

    // Register reset values.
    localparam logic [BL_W-1:0]         RST_BACKLOG_LIMIT    = 15'd1024;
    localparam logic [DM_W-1:0]         RST_DELTA_MAX        = 7'd127;
    localparam logic signed [REP_W-1:0] RST_DELTA_MIN        = -8'sd127;
    localparam logic [RPT_W-1:0]        RST_REPORTS_PER_TICK = 4'd4;

    typedef struct packed {
        logic                       req_type;
        logic signed [DX_W-1:0]     dx;
        logic signed [DX_W-1:0]     dy;
        logic                       link_ready;
    } t_in_item;

    typedef struct packed {
        logic signed [REP_W-1:0]    report_x;
        logic signed [REP_W-1:0]    report_y;
        logic                       last;
    } t_out_item;

    typedef struct packed {
        logic [BL_W-1:0]            backlog_limit;
        logic [DM_W-1:0]            delta_max;
        logic signed [REP_W-1:0]    delta_min;
        logic [RPT_W-1:0]           reports_per_tick;
    } t_cfg;

    typedef struct packed {
        logic                       is_clear;
        logic signed [DX_W-1:0]     dx;
        logic signed [DX_W-1:0]     dy;
    } t_cmd;

    typedef struct packed {
        logic                       valid;
        t_cmd                       cmd;
    } t_cmd_q;

endpackage

// ===== hdl/sdrs_regs.sv =====
module sdrs_regs
    import sdrs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    output t_cfg                 o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;

    assign w_idx  = paddr[PADDR_W-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.backlog_limit    <= RST_BACKLOG_LIMIT;
            r_cfg.delta_max        <= RST_DELTA_MAX;
            r_cfg.delta_min        <= RST_DELTA_MIN;
            r_cfg.reports_per_tick <= RST_REPORTS_PER_TICK;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_BACKLOG_LIMIT:    r_cfg.backlog_limit    <= pwdata[BL_W-1:0];
                REG_DELTA_MAX:        r_cfg.delta_max        <= pwdata[DM_W-1:0];
                REG_DELTA_MIN:        r_cfg.delta_min        <= $signed(pwdata[REP_W-1:0]);
                REG_REPORTS_PER_TICK: r_cfg.reports_per_tick <= pwdata[RPT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back; the signed register is sign-extended.
    always_comb begin
        case (w_idx)
            REG_BACKLOG_LIMIT:    prdata = PDATA_W'(r_cfg.backlog_limit);
            REG_DELTA_MAX:        prdata = PDATA_W'(r_cfg.delta_max);
            REG_DELTA_MIN:        prdata = PDATA_W'(r_cfg.delta_min);
            REG_REPORTS_PER_TICK: prdata = PDATA_W'(r_cfg.reports_per_tick);
            default:              prdata = '0;
        endcase
    end

endmodule

// ===== hdl/sdrs_front.sv =====
module sdrs_front
    import sdrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output t_cmd_q    o_q,
    input  logic      i_pop
);

    t_cmd             r_mem [Q_DEPTH];
    logic [QA_W-1:0]  r_wr;
    logic [QA_W-1:0]  r_rd;
    logic [QC_W-1:0]  r_count;
    logic             w_accept;
    logic             w_push;
    logic             w_pop;

    // An item is taken whenever the queue has room.
    assign o_in_stall = (r_count == QC_W'(Q_DEPTH));
    assign w_accept   = i_in_valid && !o_in_stall;

    // Motion with the link down is dropped here; clears and live motion go on.
    assign w_push = w_accept && (i_in_item.req_type || i_in_item.link_ready);
    assign w_pop  = i_pop && (r_count != '0);

    assign o_q.valid = (r_count != '0);
    assign o_q.cmd   = r_mem[r_rd];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr].is_clear <= i_in_item.req_type;
            r_mem[r_wr].dx       <= i_in_item.dx;
            r_mem[r_wr].dy       <= i_in_item.dy;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/sdrs_back.sv =====
module sdrs_back
    import sdrs_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_cmd_q     i_q,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item
);

    // Accumulator: backlog plus up to eight opposite reports, in counts.
    localparam int AW  = FRAC_BITS + 17;
    localparam int CW  = AW - FRAC_BITS;
    localparam int SW  = ((AW > DX_W) ? AW : DX_W) + 1;
    localparam int MW  = 16;
    localparam int NW  = MW + DM_W + 2;
    localparam int QW  = DM_W;
    localparam int STW = $clog2(QW);

    localparam logic [AW-1:0] HALF =
        {{(AW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ACC   = 9'b000000010,
        S_RND   = 9'b000000100,
        S_CHK   = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_CLAMP = 9'b001000000,
        S_EMIT  = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_back_state;

    function automatic logic signed [REP_W-1:0] clamp_rep(
        input logic signed [REP_W-1:0] v,
        input t_cfg                    cfg
    );
        logic signed [REP_W-1:0] hi;
        hi = $signed({1'b0, cfg.delta_max});
        if (v < cfg.delta_min) begin
            clamp_rep = cfg.delta_min;
        end else if (v > hi) begin
            clamp_rep = hi;
        end else begin
            clamp_rep = v;
        end
    endfunction

    // Control registers.
    t_back_state              r_state, n_state;
    logic signed [AW-1:0]     r_acc_x, n_acc_x;
    logic signed [AW-1:0]     r_acc_y, n_acc_y;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [CNT_W-1:0]         r_lim, n_lim;
    logic                     r_lane, n_lane;
    logic [STW-1:0]           r_step, n_step;
    logic                     r_pend_v, n_pend_v;
    logic                     r_out_valid, n_out_valid;

    // Payload registers.
    logic signed [DX_W-1:0]   r_dx, n_dx;
    logic signed [DX_W-1:0]   r_dy, n_dy;
    logic [MW-1:0]            r_ax, n_ax;
    logic [MW-1:0]            r_ay, n_ay;
    logic                     r_negx, n_negx;
    logic                     r_negy, n_negy;
    logic [MW-1:0]            r_mx, n_mx;
    logic [NW-1:0]            r_rem, n_rem;
    logic [NW-1:0]            r_dsh, n_dsh;
    logic [QW-1:0]            r_q, n_q;
    logic signed [REP_W-1:0]  r_sx, n_sx;
    logic signed [REP_W-1:0]  r_sy, n_sy;
    logic signed [REP_W-1:0]  r_hx, n_hx;
    logic signed [REP_W-1:0]  r_hy, n_hy;
    logic signed [REP_W-1:0]  r_pend_x, n_pend_x;
    logic signed [REP_W-1:0]  r_pend_y, n_pend_y;
    t_out_item                r_out_item, n_out_item;

    // Datapath helpers.
    logic signed [SW-1:0]     w_lim;
    logic signed [SW-1:0]     w_sum_x;
    logic signed [SW-1:0]     w_sum_y;
    logic signed [SW-1:0]     w_cl_x;
    logic signed [SW-1:0]     w_cl_y;
    logic [AW-1:0]            w_mag_x;
    logic [AW-1:0]            w_mag_y;
    logic [AW-1:0]            w_rnd_x;
    logic [AW-1:0]            w_rnd_y;
    logic [MW-1:0]            w_mx;
    logic [MW-1:0]            w_a;
    logic [MW+DM_W-1:0]       w_mul;
    logic                     w_ge;
    logic [QW-1:0]            w_qf;
    logic                     w_neg;
    logic signed [REP_W-1:0]  w_qs;
    logic signed [REP_W-1:0]  w_dx_direct;
    logic signed [REP_W-1:0]  w_dy_direct;
    logic signed [REP_W-1:0]  w_cx;
    logic signed [REP_W-1:0]  w_cy;
    logic signed [AW-1:0]     w_sub_x;
    logic signed [AW-1:0]     w_sub_y;
    logic                     w_slot;

    assign o_pop       = (r_state == S_IDLE) && i_q.valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // The output register can be loaded when empty or being taken.
    assign w_slot = !r_out_valid || !i_out_stall;

    // Add the motion and clamp to the backlog limit.
    assign w_lim   = $signed({{(SW-BL_W-FRAC_BITS){1'b0}}, i_cfg.backlog_limit,
                              {FRAC_BITS{1'b0}}});
    assign w_sum_x = SW'(r_acc_x) + SW'(r_dx);
    assign w_sum_y = SW'(r_acc_y) + SW'(r_dy);
    assign w_cl_x  = (w_sum_x < -w_lim) ? -w_lim : ((w_sum_x > w_lim) ? w_lim : w_sum_x);
    assign w_cl_y  = (w_sum_y < -w_lim) ? -w_lim : ((w_sum_y > w_lim) ? w_lim : w_sum_y);

    // Round to whole counts, half away from zero, on the magnitude.
    assign w_mag_x = r_acc_x[AW-1] ? AW'(-r_acc_x) : AW'(r_acc_x);
    assign w_mag_y = r_acc_y[AW-1] ? AW'(-r_acc_y) : AW'(r_acc_y);
    assign w_rnd_x = w_mag_x + HALF;
    assign w_rnd_y = w_mag_y + HALF;

    // Larger magnitude and the reports taken as they are when no scaling is due.
    assign w_mx        = (r_ax > r_ay) ? r_ax : r_ay;
    assign w_dx_direct = r_negx ? -$signed({1'b0, r_ax[QW-1:0]})
                                :  $signed({1'b0, r_ax[QW-1:0]});
    assign w_dy_direct = r_negy ? -$signed({1'b0, r_ay[QW-1:0]})
                                :  $signed({1'b0, r_ay[QW-1:0]});

    // Scaling numerator: magnitude times delta_max, doubled, plus rounding term.
    assign w_a   = r_lane ? r_ay : r_ax;
    assign w_mul = w_a * i_cfg.delta_max;

    // One restoring divide step a cycle; the quotient never exceeds delta_max.
    assign w_ge  = (r_rem >= r_dsh);
    assign w_qf  = {r_q[QW-2:0], w_ge};
    assign w_neg = r_lane ? r_negy : r_negx;
    assign w_qs  = w_neg ? -$signed({1'b0, w_qf}) : $signed({1'b0, w_qf});

    assign w_cx = clamp_rep(r_sx, i_cfg);
    assign w_cy = clamp_rep(r_sy, i_cfg);

    // Sent counts in accumulator scale.
    assign w_sub_x = $signed({{(CW-REP_W){r_hx[REP_W-1]}}, r_hx, {FRAC_BITS{1'b0}}});
    assign w_sub_y = $signed({{(CW-REP_W){r_hy[REP_W-1]}}, r_hy, {FRAC_BITS{1'b0}}});

    // Report sequencer. A report is held back until the next one is known,
    // so that the final one of an item can be marked.
    always_comb begin
        n_state     = r_state;
        n_acc_x     = r_acc_x;
        n_acc_y     = r_acc_y;
        n_cnt       = r_cnt;
        n_lim       = r_lim;
        n_lane      = r_lane;
        n_step      = r_step;
        n_pend_v    = r_pend_v;
        n_out_valid = r_out_valid && i_out_stall;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_negx      = r_negx;
        n_negy      = r_negy;
        n_mx        = r_mx;
        n_rem       = r_rem;
        n_dsh       = r_dsh;
        n_q         = r_q;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_hx        = r_hx;
        n_hy        = r_hy;
        n_pend_x    = r_pend_x;
        n_pend_y    = r_pend_y;
        n_out_item  = r_out_item;

        case (r_state)
            S_IDLE: begin
                if (i_q.valid) begin
                    if (i_q.cmd.is_clear) begin
                        n_acc_x = '0;
                        n_acc_y = '0;
                    end else begin
                        n_dx    = i_q.cmd.dx;
                        n_dy    = i_q.cmd.dy;
                        n_state = S_ACC;
                    end
                end
            end
            S_ACC: begin
                n_acc_x = AW'(w_cl_x);
                n_acc_y = AW'(w_cl_y);
                n_cnt   = '0;
                n_lim   = (i_cfg.reports_per_tick > CNT_W'(MAX_REPORTS))
                        ? CNT_W'(MAX_REPORTS) : i_cfg.reports_per_tick;
                n_state = S_RND;
            end
            S_RND: begin
                n_ax   = w_rnd_x[FRAC_BITS +: MW];
                n_ay   = w_rnd_y[FRAC_BITS +: MW];
                n_negx = r_acc_x[AW-1];
                n_negy = r_acc_y[AW-1];
                if (r_cnt == r_lim) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_mx   = w_mx;
                n_lane = 1'b0;
                if ((r_ax == '0) && (r_ay == '0)) begin
                    n_state = S_FIN;
                end else if (w_mx > MW'(i_cfg.delta_max)) begin
                    n_state = S_MUL;
                end else begin
                    n_sx    = w_dx_direct;
                    n_sy    = w_dy_direct;
                    n_state = S_CLAMP;
                end
            end
            S_MUL: begin
                n_rem   = NW'({w_mul, 1'b0}) + NW'(r_mx);
                n_dsh   = NW'({r_mx, 1'b0}) << (QW - 1);
                n_q     = '0;
                n_step  = STW'(QW - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_ge) begin
                    n_rem = r_rem - r_dsh;
                end
                n_dsh  = r_dsh >> 1;
                n_q    = w_qf;
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    if (r_lane) begin
                        n_sy    = w_qs;
                        n_state = S_CLAMP;
                    end else begin
                        n_sx    = w_qs;
                        n_lane  = 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            S_CLAMP: begin
                n_hx = w_cx;
                n_hy = w_cy;
                if ((w_cx == '0) && (w_cy == '0)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_pend_v || w_slot) begin
                    if (r_pend_v) begin
                        n_out_valid         = 1'b1;
                        n_out_item.report_x = r_pend_x;
                        n_out_item.report_y = r_pend_y;
                        n_out_item.last     = 1'b0;
                    end
                    n_pend_v = 1'b1;
                    n_pend_x = r_hx;
                    n_pend_y = r_hy;
                    n_acc_x  = r_acc_x - w_sub_x;
                    n_acc_y  = r_acc_y - w_sub_y;
                    n_cnt    = r_cnt + 1'b1;
                    n_state  = S_RND;
                end
            end
            S_FIN: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (w_slot) begin
                    n_out_valid         = 1'b1;
                    n_out_item.report_x = r_pend_x;
                    n_out_item.report_y = r_pend_y;
                    n_out_item.last     = 1'b1;
                    n_pend_v            = 1'b0;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_cnt       <= '0;
            r_lim       <= '0;
            r_lane      <= 1'b0;
            r_step      <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc_x     <= n_acc_x;
            r_acc_y     <= n_acc_y;
            r_cnt       <= n_cnt;
            r_lim       <= n_lim;
            r_lane      <= n_lane;
            r_step      <= n_step;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_ax       <= n_ax;
        r_ay       <= n_ay;
        r_negx     <= n_negx;
        r_negy     <= n_negy;
        r_mx       <= n_mx;
        r_rem      <= n_rem;
        r_dsh      <= n_dsh;
        r_q        <= n_q;
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_hx       <= n_hx;
        r_hy       <= n_hy;
        r_pend_x   <= n_pend_x;
        r_pend_y   <= n_pend_y;
        r_out_item <= n_out_item;
    end

endmodule

// ===== hdl/subpixel_delta_report_splitter_top.sv =====
// Sub-pixel motion report splitter. Motion items carry X/Y deltas with
// FRAC_BITS fractional bits; with the link ready they are added to two
// accumulators clamped to the backlog limit, and up to reports_per_tick
// (at most eight) byte-sized reports follow, each rounded, scaled down to
// delta_max where needed and clamped, with the final report of an item
// marked by last. A clear item zeroes the accumulators; motion with the
// link down is dropped. The front takes items into a two-entry queue, so
// it keeps accepting while the back works, until the queue is full. The
// back handles one queued item at a time: a motion item is accumulated,
// then each report is rounded and, where scaling is due, X and Y pass in
// turn through one seven-step serial divider. The final report appears
// once the one after it is known to be zero or the report count is
// reached. Output is registered; a downstream stall holds the back, and
// the input once the queue is full. Registers sit on an APB port at word
// addresses 0 to 3 and should only be written while the block is idle.
module subpixel_delta_report_splitter_top
    import sdrs_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    t_cfg    w_cfg;
    t_cmd_q  w_q;
    logic    w_pop;

    // Configuration registers.
    sdrs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Item intake and command queue.
    sdrs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_q        (w_q),
        .i_pop      (w_pop)
    );

    // Accumulation and report generation.
    sdrs_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q         (w_q),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== hdl/sdrs_checker.sv =====
module sdrs_checker
    import sdrs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_item  i_out_item
);

    localparam int RUN_W = $clog2(MAX_REPORTS);

    logic [RUN_W-1:0] r_run;

    // Count reports taken since the last marked one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (i_out_valid && !i_out_stall) begin
            if (i_out_item.last) begin
                r_run <= '0;
            end else begin
                r_run <= r_run + 1'b1;
            end
        end
    end

    // A stalled item stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_item))
        else $error("stalled output item changed");

    // Emission ends before an all-zero report.
    a_no_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_item.report_x != '0) || (i_out_item.report_y != '0))
        else $error("all-zero report emitted");

    // An item never gives more than the report cap.
    a_run_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_stall && !i_out_item.last |->
            r_run < RUN_W'(MAX_REPORTS - 1))
        else $error("too many reports without a final mark");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind subpixel_delta_report_splitter_top sdrs_checker u_sdrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);

// ===== tb/sdrs_report_checker.sv =====
`timescale 1ns / 1ps

// Watches the item channels and the register port of the report splitter.
// It keeps its own copy of the registers and the two accumulators, works
// out the reports each accepted input item should cause, and compares
// every accepted report with the oldest one still outstanding.
module sdrs_report_checker
    import sdrs_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_in_item           i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_out_item          i_out_item,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output int                 o_pending,
    output int                 o_errors,
    output int                 o_checked
);

    // Shadow copy of the registers.
    logic [BL_W-1:0]         backlog_cfg;
    logic [DM_W-1:0]         dmax_cfg;
    logic signed [REP_W-1:0] dmin_cfg;
    logic [RPT_W-1:0]        reports_cfg;

    // Accumulators in fixed point, wide enough that nothing wraps.
    longint acc_x;
    longint acc_y;

    t_out_item exp_reports[$];
    t_out_item want;
    t_reg_idx  reg_sel;
    int        err_count = 0;
    int        checked_count = 0;

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Whole counts, rounded half away from zero.
    function automatic longint to_counts(input longint a);
        longint m;
        m = (magnitude(a) + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return (a < 0) ? -m : m;
    endfunction

    // v * num / den, rounded half away from zero in exact integers.
    function automatic longint scale_to(input longint v, input longint num,
                                        input longint den);
        longint q;
        q = (2 * magnitude(v) * num + den) / (2 * den);
        return (v < 0) ? -q : q;
    endfunction

    // Lower bound first: a delta_min above delta_max wins only below delta_min.
    function automatic longint clamp_report(input longint v);
        if (v < longint'(dmin_cfg)) begin
            return longint'(dmin_cfg);
        end
        if (v > longint'(dmax_cfg)) begin
            return longint'(dmax_cfg);
        end
        return v;
    endfunction

    function automatic longint clamp_backlog(input longint v, input longint lim);
        if (v < -lim) begin
            return -lim;
        end
        if (v > lim) begin
            return lim;
        end
        return v;
    endfunction

    // Updates the accumulators for one input item and queues its reports.
    task automatic predict_reports(input t_in_item it);
        t_out_item burst[MAX_REPORTS];
        longint    lim;
        longint    ox;
        longint    oy;
        longint    mx;
        longint    sx;
        longint    sy;
        longint    hx;
        longint    hy;
        int        n_max;
        int        n;
        // A clear item zeroes the accumulators whatever the link does.
        if (it.req_type) begin
            acc_x = 0;
            acc_y = 0;
            return;
        end
        if (!it.link_ready) begin
            return;
        end
        lim   = longint'(backlog_cfg) <<< FRAC_BITS;
        acc_x = clamp_backlog(acc_x + longint'($signed(it.dx)), lim);
        acc_y = clamp_backlog(acc_y + longint'($signed(it.dy)), lim);
        n_max = (reports_cfg > MAX_REPORTS) ? MAX_REPORTS : int'(reports_cfg);
        n     = 0;
        while (n < n_max) begin
            ox = to_counts(acc_x);
            oy = to_counts(acc_y);
            if (ox == 0 && oy == 0) begin
                break;
            end
            mx = (magnitude(ox) > magnitude(oy)) ? magnitude(ox) : magnitude(oy);
            sx = ox;
            sy = oy;
            // Scale both axes together so the larger one lands on delta_max.
            if (mx > longint'(dmax_cfg)) begin
                sx = scale_to(ox, longint'(dmax_cfg), mx);
                sy = scale_to(oy, longint'(dmax_cfg), mx);
            end
            hx = clamp_report(sx);
            hy = clamp_report(sy);
            if (hx == 0 && hy == 0) begin
                break;
            end
            burst[n].report_x = hx[REP_W-1:0];
            burst[n].report_y = hy[REP_W-1:0];
            burst[n].last     = 1'b0;
            acc_x = acc_x - (hx <<< FRAC_BITS);
            acc_y = acc_y - (hy <<< FRAC_BITS);
            n++;
        end
        for (int k = 0; k < n; k++) begin
            if (k == n - 1) begin
                burst[k].last = 1'b1;
            end
            exp_reports.push_back(burst[k]);
        end
    endtask

    task automatic check_field(input string fname, input logic signed [REP_W-1:0] wanted,
                               input logic signed [REP_W-1:0] actual);
        if (actual !== wanted) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, wanted,
                     actual);
            err_count++;
        end
    endtask

    // Register writes, then prediction, then comparison, all on accepted edges.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            backlog_cfg = RST_BACKLOG_LIMIT;
            dmax_cfg    = RST_DELTA_MAX;
            dmin_cfg    = RST_DELTA_MIN;
            reports_cfg = RST_REPORTS_PER_TICK;
            acc_x       = 0;
            acc_y       = 0;
            exp_reports.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                reg_sel = i_paddr[PADDR_W-1:2];
                case (reg_sel)
                    REG_BACKLOG_LIMIT:    backlog_cfg = i_pwdata[BL_W-1:0];
                    REG_DELTA_MAX:        dmax_cfg    = i_pwdata[DM_W-1:0];
                    REG_DELTA_MIN:        dmin_cfg    = i_pwdata[REP_W-1:0];
                    REG_REPORTS_PER_TICK: reports_cfg = i_pwdata[RPT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_reports(i_in_item);
            end
            if (i_out_valid && !i_out_stall) begin
                if (exp_reports.size() == 0) begin
                    $display("%0t: report with none outstanding, expected nothing, got x=%0d y=%0d last=%0b",
                             $time, $signed(i_out_item.report_x),
                             $signed(i_out_item.report_y), i_out_item.last);
                    err_count++;
                end else begin
                    want = exp_reports.pop_front();
                    check_field("report_x", want.report_x, i_out_item.report_x);
                    check_field("report_y", want.report_y, i_out_item.report_y);
                    check_field("last", $signed({{(REP_W-1){1'b0}}, want.last}),
                                $signed({{(REP_W-1){1'b0}}, i_out_item.last}));
                    checked_count++;
                end
            end
        end
        o_pending <= exp_reports.size();
        o_errors  <= err_count;
        o_checked <= checked_count;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Drives motion and clear items into the report splitter under a series of
// register settings, with random gaps on the input and random stalls on the
// output, and leaves the report checking to the report checker.
module tb
    import sdrs_pkg::*;
();

    localparam int FRAC_BITS    = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 120;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;

    localparam logic REQ_MOTION = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    localparam logic signed [DX_W-1:0] DX_MAX = {1'b0, {(DX_W-1){1'b1}}};
    localparam logic signed [DX_W-1:0] DX_MIN = {1'b1, {(DX_W-1){1'b0}}};

    logic               clk;
    logic               rst_n    = 1'b0;
    logic               in_valid = 1'b0;
    t_in_item           in_item  = '0;
    logic               out_stall = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;

    logic               in_stall;
    logic               out_valid;
    t_out_item          out_item;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int  chk_pending;
    int  chk_errors;
    int  chk_checked;

    logic no_idle = 1'b0;
    logic hold_go = 1'b0;
    logic hold_on = 1'b0;
    int   rx_wait = 0;
    int   cycle_count = 0;

    int n_motion  = 0;
    int n_dropped = 0;
    int n_clear   = 0;
    int n_settings = 0;

    subpixel_delta_report_splitter_top #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    sdrs_report_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) checker_i (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_stall (in_stall),
        .i_in_item  (in_item),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out_item (out_item),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_pready   (pready),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_pending  (chk_pending),
        .o_errors   (chk_errors),
        .o_checked  (chk_checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up if the run takes far longer than the slowest correct one.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    // Report receiver: a random stall before each item, and the long hold-off.
    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            rx_wait = no_idle ? 0 : $urandom_range(0, 12);
        end
        if (hold_on) begin
            out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            if (out_valid) begin
                rx_wait--;
            end
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Holds the receiver off long enough for the queue to fill and the
    // input to stall while items keep being offered.
    initial begin
        wait (hold_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    function automatic t_in_item mk_item(input logic req, input logic signed [DX_W-1:0] dx,
                                         input logic signed [DX_W-1:0] dy, input logic rdy);
        t_in_item it;
        it.req_type   = req;
        it.dx         = dx;
        it.dy         = dy;
        it.link_ready = rdy;
        return it;
    endfunction

    // Sub-pixel, moderate and full-range deltas, plus the edges of the field.
    function automatic logic signed [DX_W-1:0] rand_delta();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 767) - 384;
            1: v = $urandom_range(0, 131072) - 65536;
            2: v = $urandom;
            default: begin
                case ($urandom_range(0, 5))
                    0: v = 8388607;
                    1: v = -8388608;
                    2: v = 128;
                    3: v = -128;
                    4: v = 0;
                    default: v = -1;
                endcase
            end
        endcase
        return v[DX_W-1:0];
    endfunction

    // Mostly motion with the link up; some clears and some dropped motion.
    function automatic t_in_item rand_item();
        int pick;
        logic rdy;
        pick = $urandom_range(0, 99);
        if (pick < 7) begin
            rdy = ($urandom_range(0, 1) != 0);
            return mk_item(REQ_CLEAR, rand_delta(), rand_delta(), rdy);
        end
        rdy = (pick >= 17);
        return mk_item(REQ_MOTION, rand_delta(), rand_delta(), rdy);
    endfunction

    // Offers one item after a random gap and waits until it is taken.
    task automatic push_item(input t_in_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        if (it.req_type == REQ_CLEAR) begin
            n_clear++;
        end else if (!it.link_ready) begin
            n_dropped++;
        end else begin
            n_motion++;
        end
    endtask

    task automatic run_random(input int n, input logic quiet);
        no_idle = quiet;
        for (int k = 0; k < n; k++) begin
            push_item(rand_item());
        end
    endtask

    // Waits until every report has arrived and items without reports are done.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Unused upper data bits carry junk, which the registers must ignore.
    task automatic set_config(input logic [BL_W-1:0] bl, input logic [DM_W-1:0] dm,
                              input logic signed [REP_W-1:0] dmn,
                              input logic [RPT_W-1:0] rpt);
        logic [PDATA_W-1:0] junk;
        wait_idle();
        junk = $urandom;
        apb_write(REG_BACKLOG_LIMIT, {junk[PDATA_W-1:BL_W], bl});
        apb_write(REG_DELTA_MAX, {junk[PDATA_W-1:DM_W], dm});
        apb_write(REG_DELTA_MIN, {junk[PDATA_W-1:REP_W], dmn});
        apb_write(REG_REPORTS_PER_TICK, {junk[PDATA_W-1:RPT_W], rpt});
        n_settings++;
    endtask

    // Rounding edges, dropped motion, full-scale deltas and scaling ratios.
    task automatic run_directed();
        push_item(mk_item(REQ_CLEAR, 24'sd0, 24'sd0, 1'b0));
        push_item(mk_item(REQ_MOTION, 24'sd127, -24'sd127, 1'b1));
        push_item(mk_item(REQ_MOTION, 24'sd128, -24'sd128, 1'b1));
        push_item(mk_item(REQ_CLEAR, DX_MAX, DX_MIN, 1'b1));
        push_item(mk_item(REQ_MOTION, DX_MAX, DX_MAX, 1'b0));
        push_item(mk_item(REQ_MOTION, DX_MAX, DX_MIN, 1'b1));
        push_item(mk_item(REQ_MOTION, DX_MIN, DX_MAX, 1'b1));
        push_item(mk_item(REQ_CLEAR, 24'sd0, 24'sd0, 1'b1));
        push_item(mk_item(REQ_MOTION, DX_W'(300 * 256), DX_W'(100 * 256), 1'b1));
        push_item(mk_item(REQ_CLEAR, 24'sd0, 24'sd0, 1'b1));
        push_item(mk_item(REQ_MOTION, DX_W'(-127 * 256), DX_W'(127 * 256), 1'b1));
        push_item(mk_item(REQ_CLEAR, 24'sd0, 24'sd0, 1'b1));
        push_item(mk_item(REQ_MOTION, DX_W'(-128 * 256), 24'sd0, 1'b1));
        push_item(mk_item(REQ_MOTION, 24'sd0, 24'sd0, 1'b1));
        push_item(mk_item(REQ_MOTION, 24'sd1, -24'sd1, 1'b1));
        push_item(mk_item(REQ_MOTION, 24'sh555555, 24'shAAAAAA, 1'b1));
        push_item(mk_item(REQ_MOTION, -24'sd1, 24'sd0, 1'b1));
        push_item(mk_item(REQ_CLEAR, DX_MIN, DX_MAX, 1'b0));
    endtask

    // Main sequence: reset, then one phase per register setting.
    initial begin
        int bl;
        int dm;
        int dmn;
        int rpt;
        int k;
        int fails;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of the registers.
        n_settings = 1;
        run_directed();
        run_random(30, 1'b0);

        // Widest limits, with the receiver held off for a long stretch.
        set_config(15'd32767, 7'd127, 8'sh80, 4'd8);
        hold_go <= 1'b1;
        run_random(35, 1'b0);

        // Narrowest sensible limits, with no idling on either side.
        set_config(15'd1, 7'd1, -8'sd1, 4'd1);
        run_random(15, 1'b1);

        // Zero backlog limit and a report count above eight.
        set_config(15'd0, 7'd64, -8'sd64, 4'd15);
        run_random(10, 1'b0);

        // Zero delta_max ends emission at the first scaled report.
        set_config(15'd2000, 7'd0, -8'sd20, 4'd3);
        run_random(10, 1'b0);

        // Non-negative delta_min, below delta_max and then above it.
        set_config(15'd400, 7'd5, 8'sd3, 4'd12);
        run_random(15, 1'b1);
        set_config(15'd400, 7'd2, 8'sd6, 4'd0);
        run_random(10, 1'b0);
        set_config(15'd400, 7'd2, 8'sd6, 4'd5);
        run_random(15, 1'b0);

        // A few random settings within the normal ranges.
        for (k = 0; k < 3; k++) begin
            bl  = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 600)
                                              : $urandom_range(1, 32767);
            dm  = $urandom_range(1, 127);
            dmn = -int'($urandom_range(1, 128));
            rpt = $urandom_range(1, 8);
            set_config(BL_W'(bl), DM_W'(dm), REP_W'(dmn), RPT_W'(rpt));
            run_random(25, k == 1);
        end

        // Drain, then allow the block to finish items that give no report.
        in_valid <= 1'b0;
        @(posedge clk);
        for (k = 0; k < DRAIN_LIMIT && chk_pending != 0; k++) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        if (chk_pending != 0) begin
            $display("%0t: %0d expected reports never arrived", $time, chk_pending);
        end
        fails = chk_errors + chk_pending;
        $display("Run covered %0d motion items, %0d with the link down and %0d clears,",
                 n_motion, n_dropped, n_clear);
        $display("over %0d register settings, with %0d reports compared.",
                 n_settings, chk_checked);
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sdrs_pkg.sv
hdl/sdrs_regs.sv
hdl/sdrs_front.sv
hdl/sdrs_back.sv
hdl/subpixel_delta_report_splitter_top.sv
hdl/sdrs_checker.sv
tb/sdrs_report_checker.sv
tb/tb.sv
